// File: rtl/core/mstt_pkg.sv
// Shared types and codes for the tick timer table.
// Used by the slot RAM, the top level and the testbench.
package mstt_pkg;

    localparam int PERIOD_W = 16;
    localparam int REPS_W   = 8;
    localparam int HANDLE_W = 4;
    localparam int MASK_W   = 16;
    localparam int ACNT_W   = 5;
    localparam int OP_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_SCHEDULE   = 2'd1,
        OP_CANCEL     = 2'd2,
        OP_CANCEL_ALL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] reload;
        logic [PERIOD_W-1:0] remaining;
        logic [REPS_W-1:0]   repeats;
    } slot_entry_t;

endpackage

// File: rtl/core/mstt_slot_ram.sv
// Slot RAM: one entry per timer slot, one write and one registered read port.
// Depends on mstt_pkg for the entry layout.
module mstt_slot_ram #(
    parameter int DEPTH = 16,
    parameter int ADDR_W = 4
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  mstt_pkg::slot_entry_t     wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output mstt_pkg::slot_entry_t     rdata
);

    mstt_pkg::slot_entry_t mem [DEPTH];
    mstt_pkg::slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/multi_slot_tick_timer_table_unit.sv
// Top level of the tick timer table: control, slot flags and output register.
// Depends on mstt_pkg and mstt_slot_ram.
//
// A table of SLOTS countdown timers. Each input word carries an opcode in
// s_tuser: tick, schedule, cancel one handle, cancel all. Exactly one result
// word comes back for each input word. Period, reload value and repeats live
// in a single-port-read RAM; the free/active flag of each slot sits in a
// flip-flop, so reset frees the whole table at once with no clearing pass.
// Operation: a tick walks every slot through the RAM, one read-modify-write per
// cycle; a schedule scans the slot flags lowest first, one slot per cycle, and
// reports an error when the table is full; a cancel, a cancel-all or a schedule
// with a zero period goes straight to the result. A new input word is taken
// while the previous result still waits in the output register.
module multi_slot_tick_timer_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    input  logic [31:0] s_tdata,   // period_ticks[15:0], repeat_count[23:16], handle[27:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // error[0]
    output logic [31:0] m_tdata    // slot_handle[3:0], fired_mask[19:4],
                                   // active_count[24:20], tick_enable[25]
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    mstt_pkg::state_t state_reg, state_next;

    logic [SLOTS-1:0]                active_reg, active_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                ptr_reg, ptr_next;
    logic                            pend_reg, pend_next;
    logic [IDX_W-1:0]                pidx_reg, pidx_next;
    logic [mstt_pkg::PERIOD_W-1:0]   period_reg, period_next;
    logic [mstt_pkg::REPS_W-1:0]     reps_reg, reps_next;
    logic [mstt_pkg::MASK_W-1:0]     fired_reg, fired_next;
    logic [mstt_pkg::HANDLE_W-1:0]   handle_reg, handle_next;
    logic                            err_reg, err_next;
    logic                            out_valid_reg, out_valid_next;
    logic [31:0]                     out_tdata_reg, out_tdata_next;
    logic                            out_tuser_reg, out_tuser_next;

    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    mstt_pkg::slot_entry_t           ram_wdata;
    mstt_pkg::slot_entry_t           ram_rdata;

    mstt_pkg::op_t                   in_op;
    logic [mstt_pkg::PERIOD_W-1:0]   in_period;
    logic [mstt_pkg::REPS_W-1:0]     in_reps;
    logic [6:0]                      in_handle_w;
    logic [6:0]                      pidx_w;
    logic [6:0]                      ptr_w;
    logic [6:0]                      count_w;
    logic [mstt_pkg::PERIOD_W-1:0]   rem_dec;
    logic                            ptr_done;
    logic                            out_free;
    logic [mstt_pkg::ACNT_W-1:0]     acnt;

    assign in_op       = mstt_pkg::op_t'(s_tuser);
    assign in_period   = s_tdata[15:0];
    assign in_reps     = s_tdata[23:16];
    assign in_handle_w = 7'(s_tdata[27:24]);
    assign pidx_w      = 7'(pidx_reg);
    assign ptr_w       = 7'(ptr_reg);
    assign count_w     = 7'(count_reg);
    assign rem_dec     = ram_rdata.remaining - 16'd1;
    assign ptr_done    = (ptr_reg == CNT_W'(SLOTS));
    assign out_free    = !out_valid_reg || m_tready;
    assign acnt        = (count_w > 7'd31) ? 5'd31 : count_w[4:0];

    assign s_tready = (state_reg == mstt_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

    mstt_slot_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mstt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (in_op)
                        mstt_pkg::OP_TICK:       state_next = mstt_pkg::ST_SWEEP;
                        mstt_pkg::OP_SCHEDULE:   state_next = (in_period == '0) ?
                                                     mstt_pkg::ST_FINISH : mstt_pkg::ST_SCAN;
                        mstt_pkg::OP_CANCEL:     state_next = mstt_pkg::ST_FINISH;
                        mstt_pkg::OP_CANCEL_ALL: state_next = mstt_pkg::ST_FINISH;
                    endcase
                end
            end
            mstt_pkg::ST_SWEEP:
            begin
                if (ptr_done && !pend_reg)
                begin
                    state_next = mstt_pkg::ST_FINISH;
                end
            end
            mstt_pkg::ST_SCAN:
            begin
                if (ptr_done || !active_reg[ptr_reg[IDX_W-1:0]])
                begin
                    state_next = mstt_pkg::ST_FINISH;
                end
            end
            mstt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mstt_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        active_next    = active_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        period_next    = period_reg;
        reps_next      = reps_reg;
        fired_next     = fired_reg;
        handle_next    = handle_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_tdata_next = out_tdata_reg;
        out_tuser_next = out_tuser_reg;
        ram_we         = 1'b0;
        ram_waddr      = pidx_reg;
        ram_wdata      = ram_rdata;

        unique case (state_reg)
            mstt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ptr_next    = '0;
                    fired_next  = '0;
                    handle_next = '0;
                    err_next    = 1'b0;
                    period_next = in_period;
                    reps_next   = in_reps;
                    unique case (in_op)
                        mstt_pkg::OP_TICK:
                        begin
                        end
                        mstt_pkg::OP_SCHEDULE:
                        begin
                            err_next = (in_period == '0);
                        end
                        mstt_pkg::OP_CANCEL:
                        begin
                            if ((in_handle_w < 7'(SLOTS)) &&
                                active_reg[in_handle_w[IDX_W-1:0]])
                            begin
                                active_next[in_handle_w[IDX_W-1:0]] = 1'b0;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        mstt_pkg::OP_CANCEL_ALL:
                        begin
                            active_next = '0;
                            count_next  = '0;
                        end
                    endcase
                end
            end
            mstt_pkg::ST_SWEEP:
            begin
                // issue the read of the next slot while the previous one is updated
                if (!ptr_done)
                begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[IDX_W-1:0];
                    ptr_next  = ptr_reg + CNT_W'(1);
                end
                if (pend_reg && active_reg[pidx_reg])
                begin
                    ram_we = 1'b1;
                    ram_wdata.remaining = rem_dec;
                    if (rem_dec == '0)
                    begin
                        if (pidx_w < 7'(mstt_pkg::MASK_W))
                        begin
                            fired_next[pidx_w[3:0]] = 1'b1;
                        end
                        priority if (ram_rdata.repeats == '0)
                        begin
                            ram_wdata.remaining = ram_rdata.reload;
                        end
                        else if (ram_rdata.repeats == 8'd1)
                        begin
                            active_next[pidx_reg] = 1'b0;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            ram_wdata.repeats   = ram_rdata.repeats - 8'd1;
                            ram_wdata.remaining = ram_rdata.reload;
                        end
                    end
                end
            end
            mstt_pkg::ST_SCAN:
            begin
                priority if (ptr_done)
                begin
                    err_next = 1'b1;
                end
                else if (!active_reg[ptr_reg[IDX_W-1:0]])
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = ptr_reg[IDX_W-1:0];
                    ram_wdata.reload    = period_reg;
                    ram_wdata.remaining = period_reg;
                    ram_wdata.repeats   = reps_reg;
                    active_next[ptr_reg[IDX_W-1:0]] = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    handle_next = ptr_w[3:0];
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            mstt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_tuser_next = err_reg;
                    out_tdata_next = {6'd0, (count_reg != '0), acnt, fired_reg, handle_reg};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mstt_pkg::ST_IDLE;
            active_reg    <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg      <= pidx_next;
        period_reg    <= period_next;
        reps_reg      <= reps_next;
        fired_reg     <= fired_next;
        handle_reg    <= handle_next;
        err_reg       <= err_next;
        out_tdata_reg <= out_tdata_next;
        out_tuser_reg <= out_tuser_next;
    end

endmodule

// File: rtl/core/mstt_checker.sv
// Port-level checks for the tick timer table, bound to the top level.
// Sees only the top-level ports; no package dependency.
module mstt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tuser,
    input logic [31:0] m_tdata
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_enable_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[25] == (m_tdata[24:20] != 5'd0)))
        else $error("tick_enable disagrees with active_count");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[19:0] == 20'd0))
        else $error("rejected schedule carries handle or fired bits");

    a_fired_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[19:4] != 16'd0) |-> (m_tdata[3:0] == 4'd0) && !m_tuser)
        else $error("tick result carries a handle or an error");

endmodule

bind multi_slot_tick_timer_table_unit mstt_checker u_mstt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for multi_slot_tick_timer_table_unit: streams opcode words in and
// checks every result word against a built-in predictor of the slot table.
// Depends on mstt_pkg and the RTL of the timer table.
module tb;

    localparam int NUM_SLOTS    = 16;
    localparam int ITEMS_PER_PH = 270;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [3:0]  slot_handle;
        logic        rejected;
        logic [15:0] fired_mask;
        logic [4:0]  active_count;
        logic        tick_enable;
    } timer_result_t;

    // Shadow copy of the slot table; predicts one result word per input word.
    class timer_table_checker;
        bit [15:0]     reload_period [NUM_SLOTS];
        bit [15:0]     remaining     [NUM_SLOTS];
        bit [7:0]      repeats_left  [NUM_SLOTS];
        int unsigned   slots_in_use;
        timer_result_t pending_results [$];
        int unsigned   errors;

        function void release_slot(int s);
            if (reload_period[s] != 0) begin
                reload_period[s] = 0;
                slots_in_use--;
            end
        endfunction

        function void note_accepted_word(mstt_pkg::op_t op, bit [15:0] period,
                                         bit [7:0] reps, bit [3:0] handle);
            timer_result_t r;
            r = '0;
            case (op)
                mstt_pkg::OP_TICK: begin
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        if (reload_period[s] != 0) begin
                            remaining[s]--;
                            if (remaining[s] == 0) begin
                                r.fired_mask[s] = 1'b1;
                                if (repeats_left[s] == 1)
                                    release_slot(s);
                                else begin
                                    // zero repeats means forever: reload without counting
                                    if (repeats_left[s] != 0)
                                        repeats_left[s]--;
                                    remaining[s] = reload_period[s];
                                end
                            end
                        end
                    end
                end
                mstt_pkg::OP_SCHEDULE: begin
                    r.rejected = 1'b1;
                    if (period != 0) begin
                        for (int s = 0; s < NUM_SLOTS && r.rejected; s++) begin
                            if (reload_period[s] == 0) begin
                                reload_period[s] = period;
                                remaining[s]     = period;
                                repeats_left[s]  = reps;
                                slots_in_use++;
                                r.slot_handle    = 4'(s);
                                r.rejected       = 1'b0;
                            end
                        end
                    end
                end
                mstt_pkg::OP_CANCEL:
                    release_slot(int'(handle));
                mstt_pkg::OP_CANCEL_ALL:
                    for (int s = 0; s < NUM_SLOTS; s++)
                        release_slot(s);
                default: ;
            endcase
            r.active_count = 5'(slots_in_use);
            r.tick_enable  = (slots_in_use != 0);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result_word(logic err_bit, logic [31:0] data);
            timer_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h/%h",
                         $time, err_bit, data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("slot_handle",  32'(want.slot_handle),  32'(data[3:0]));
            compare_field("error",        32'(want.rejected),     32'(err_bit));
            compare_field("fired_mask",   32'(want.fired_mask),   32'(data[19:4]));
            compare_field("active_count", 32'(want.active_count), 32'(data[24:20]));
            compare_field("tick_enable",  32'(want.tick_enable),  32'(data[25]));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // opcode[1:0]
    logic [31:0] s_tdata;   // period_ticks[15:0], repeat_count[23:16], handle[27:24]
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tuser;   // error[0]
    logic [31:0] m_tdata;   // slot_handle[3:0], fired_mask[19:4],
                            // active_count[24:20], tick_enable[25]

    timer_table_checker table_check;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_off_req;
    int unsigned quiet_cycles;

    multi_slot_tick_timer_table_unit #(.SLOTS(NUM_SLOTS)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor both sides at each edge and watch for a stalled run.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                table_check.check_result_word(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                table_check.note_accepted_word(mstt_pkg::op_t'(s_tuser), s_tdata[15:0],
                                               s_tdata[23:16], s_tdata[27:24]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_word(mstt_pkg::op_t op, bit [15:0] period, bit [7:0] reps,
                             bit [3:0] handle);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, handle, reps, period};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_schedule_burst();
        repeat (NUM_SLOTS + 1)
            send_word(mstt_pkg::OP_SCHEDULE, 16'($urandom_range(1, 6)),
                      8'($urandom_range(0, 3)), 4'd0);
    endtask

    task automatic send_random_word();
        int unsigned pick;
        bit [15:0]   period;
        bit [7:0]    reps;
        pick = $urandom_range(99);
        // mostly short periods and few repeats so slots fire and free often
        if ($urandom_range(99) < 85)
            period = 16'($urandom_range(1, 8));
        else if ($urandom_range(99) < 30)
            period = 16'd0;
        else
            period = 16'($urandom_range(65535));
        reps = ($urandom_range(99) < 60) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(255));
        if (pick < 40)
            send_word(mstt_pkg::OP_TICK, 16'($urandom_range(65535)),
                      8'($urandom_range(255)), 4'($urandom_range(15)));
        else if (pick < 75)
            send_word(mstt_pkg::OP_SCHEDULE, period, reps, 4'($urandom_range(15)));
        else if (pick < 94)
            send_word(mstt_pkg::OP_CANCEL, 16'($urandom_range(65535)),
                      8'($urandom_range(255)), 4'($urandom_range(15)));
        else
            send_word(mstt_pkg::OP_CANCEL_ALL, 16'($urandom_range(65535)),
                      8'($urandom_range(255)), 4'($urandom_range(15)));
    endtask

    initial
    begin
        table_check   = new;
        send_idle_pct = 14;
        recv_idle_pct = 66;
        hold_off_req  = 1'b0;
        quiet_cycles  = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= mstt_pkg::OP_TICK;
        s_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, zero period, one-shot, forever, extremes, free cancel.
        send_word(mstt_pkg::OP_CANCEL_ALL, 16'd0, 8'd0, 4'd0);
        send_word(mstt_pkg::OP_SCHEDULE, 16'd0, 8'd7, 4'd0);
        send_word(mstt_pkg::OP_SCHEDULE, 16'd1, 8'd1, 4'd0);
        send_word(mstt_pkg::OP_TICK, 16'd0, 8'd0, 4'd0);
        send_word(mstt_pkg::OP_SCHEDULE, 16'd2, 8'd0, 4'd0);
        send_word(mstt_pkg::OP_SCHEDULE, 16'hFFFF, 8'hFF, 4'hF);
        send_word(mstt_pkg::OP_SCHEDULE, 16'd3, 8'd2, 4'd0);
        send_word(mstt_pkg::OP_TICK, 16'hFFFF, 8'hFF, 4'hF);
        send_word(mstt_pkg::OP_TICK, 16'd0, 8'd0, 4'd0);
        send_word(mstt_pkg::OP_CANCEL, 16'd0, 8'd0, 4'd1);
        send_word(mstt_pkg::OP_CANCEL, 16'd0, 8'd0, 4'd1);
        send_word(mstt_pkg::OP_CANCEL, 16'd0, 8'd0, 4'hF);
        // Fill the table, overflow it, tick the full table so several slots fire, then clear.
        for (int s = 0; s < NUM_SLOTS - 2; s++)
            send_word(mstt_pkg::OP_SCHEDULE, 16'(s % 4 + 1), 8'(s % 3), 4'd0);
        send_word(mstt_pkg::OP_SCHEDULE, 16'd5, 8'd1, 4'd0);
        send_word(mstt_pkg::OP_TICK, 16'd0, 8'd0, 4'd0);
        send_word(mstt_pkg::OP_CANCEL_ALL, 16'd0, 8'd0, 4'd0);

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 66;
                recv_idle_pct = 14;
            end
            else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_off_req  = 1'b1;
            end
            for (int i = 0; i < ITEMS_PER_PH; i++) begin
                if ($urandom_range(99) < 1)
                    send_schedule_burst();
                else
                    send_random_word();
            end
        end
        s_tvalid <= 1'b0;

        while (table_check.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_check.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/mstt_pkg.sv
rtl/core/mstt_slot_ram.sv
rtl/core/multi_slot_tick_timer_table_unit.sv
rtl/core/mstt_checker.sv
verif/tb.sv
